### rtl/rhh_pkg.sv
// Package: sizes, command and status codes, and payload types for the Robin Hood hash table.
`timescale 1ns / 1ps
package rhh_pkg;
  localparam int TableSize = 1024;
  localparam int IdxW = $clog2(TableSize);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 32;
  localparam int DataW = 32;
  localparam int EntryW = KeyW + DataW + IdxW;
  // Slot memory word: valid flag on top of the entry
  localparam int SlotW = EntryW + 1;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;

  localparam logic [10:0] LoadLimitReset = 11'd716;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] data;
    logic [31:0] key_hash;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_data;
    logic [9:0]  slot;
    logic [10:0] entry_count;
  } rsp_t;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [1:0]      cmd;
    logic [KeyW-1:0] key;
    logic [DataW-1:0] data;
    logic [IdxW-1:0] home;
  } op_t;
endpackage

### rtl/rhh_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rhh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/rhh_front.sv
// Front end: accepts requests, masks fields and queues operations for the back end.
`timescale 1ns / 1ps
module rhh_front import rhh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_item,
  output logic op_valid,
  input  logic op_ready,
  output op_t  op
);
  localparam int Depth = 2;
  op_t q [Depth];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  op_t incoming;

  assign incoming = '{cmd: in_item.cmd, key: in_item.key[KeyW-1:0],
                      data: in_item.data[DataW-1:0],
                      home: in_item.key_hash[IdxW-1:0]};
  assign in_ready = (cnt != 2'd2);
  assign op_valid = (cnt != 2'd0);
  assign op = q[rp];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) begin
        q[wp] <= incoming;
        wp <= wp + 1'b1;
      end
      if (op_valid && op_ready) rp <= rp + 1'b1;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(op_valid && op_ready);
    end
  end
endmodule

### rtl/rhh_back.sv
// Back end: probe walks, Robin Hood insert and backward-shift delete over the slot memory.
`timescale 1ns / 1ps
module rhh_back import rhh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  input  logic [10:0] load_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_item
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_FRD = 4'd2, S_FCHK = 4'd3,
                         S_DEC = 4'd4, S_IRD = 4'd5, S_ICHK = 4'd6, S_RRD = 4'd7,
                         S_RCHK = 4'd8, S_OUT = 4'd9;
  logic [3:0] state;

  logic [IdxW-1:0] addr, idx, found_idx, first;
  logic [CntW-1:0] count, n, probe, off_w;
  logic placed;
  op_t cur;
  logic we, rm_stop;
  logic [SlotW-1:0] wdata, rdata;
  logic r_valid;
  logic [KeyW-1:0] r_key;
  logic [DataW-1:0] r_data;
  logic [IdxW-1:0] r_home, off, nxt;
  logic [EntryW-1:0] carry;
  rsp_t rsp;

  assign {r_valid, r_key, r_data, r_home} = rdata;
  assign off = idx - r_home;
  assign off_w = {1'b0, off};
  assign nxt = idx + 1'b1;
  // Backward shift ends at a free slot, an entry at home, or the walk bound
  assign rm_stop = !r_valid || r_home == idx || n == CntW'(TableSize);

  rhh_ram #(.Width(SlotW), .Depth(TableSize)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign op_ready = (state == S_IDLE) && !out_valid;
  assign out_item = rsp;

  always_comb begin
    we = 1'b0; wdata = {1'b1, carry}; addr = idx;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_ICHK: if (!r_valid || probe > off_w) we = 1'b1;
      S_RCHK: begin
        addr = found_idx;
        we = 1'b1;
        wdata = rm_stop ? '0 : rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; idx <= '0; count <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        // Clearing pass: one slot per cycle after reset
        S_CLR: begin
          idx <= nxt;
          if (idx == IdxW'(TableSize - 1)) state <= S_IDLE;
        end
        S_IDLE: if (op_valid && !out_valid) begin
          cur <= op; idx <= op.home; probe <= '0; n <= '0;
          rsp <= '{status: ST_NOT_FOUND, found_data: '0, slot: '0, entry_count: '0};
          state <= (op.cmd == CMD_INSERT || op.cmd == CMD_SEARCH || op.cmd == CMD_REMOVE)
                   ? S_FRD : S_OUT;
        end
        S_FRD: state <= S_FCHK;
        // One find step per read
        S_FCHK: begin
          if (!r_valid || n == CntW'(TableSize)) state <= S_DEC;
          else if (r_key == cur.key) begin
            found_idx <= idx; rsp.slot <= idx;
            unique case (cur.cmd)
              CMD_INSERT: begin rsp.status <= ST_DUPLICATE; state <= S_OUT; end
              CMD_SEARCH: begin
                rsp.status <= ST_FOUND; rsp.found_data <= r_data; state <= S_OUT;
              end
              default: begin
                rsp.status <= ST_REMOVED; rsp.found_data <= r_data;
                idx <= nxt; n <= '0; state <= S_RRD;
              end
            endcase
          end else if (off_w < probe) state <= S_DEC;
          else begin
            probe <= probe + 1'b1; idx <= nxt; n <= n + 1'b1; state <= S_FRD;
          end
        end
        S_DEC: begin
          if (cur.cmd == CMD_INSERT) begin
            if (count > CntW'(load_limit) || count >= CntW'(TableSize)) begin
              rsp.status <= ST_FULL; state <= S_OUT;
            end else begin
              rsp.status <= ST_INSERTED;
              carry <= {cur.key, cur.data, cur.home};
              idx <= cur.home; probe <= '0; placed <= 1'b0; n <= '0;
              state <= S_IRD;
            end
          end else state <= S_OUT;
        end
        S_IRD: state <= S_ICHK;
        // Robin Hood placement step
        S_ICHK: begin
          if (!r_valid) begin
            count <= count + 1'b1;
            rsp.slot <= placed ? first : idx; state <= S_OUT;
          end else begin
            if (probe > off_w) begin
              carry <= rdata[EntryW-1:0];
              if (!placed) begin first <= idx; placed <= 1'b1; end
              probe <= off_w + 1'b1;
            end else probe <= probe + 1'b1;
            idx <= nxt; n <= n + 1'b1;
            state <= (n == CntW'(TableSize - 1)) ? S_OUT : S_IRD;
            if (n == CntW'(TableSize - 1)) rsp.slot <= placed ? first : '0;
          end
        end
        S_RRD: state <= S_RCHK;
        // Backward shift: idx is the follower, found_idx the hole
        S_RCHK: begin
          if (rm_stop) begin
            if (count != '0) count <= count - 1'b1;
            state <= S_OUT;
          end else begin
            found_idx <= idx; idx <= nxt; n <= n + 1'b1; state <= S_RRD;
          end
        end
        S_OUT: begin
          rsp.entry_count <= count; out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/robin_hood_hash_table_core.sv
// Top level of the Robin Hood hash table.
`timescale 1ns / 1ps
// Open-addressing table of 1024 slots with linear probing, Robin Hood insert and
// backward-shift remove; one response per request. After reset the back end clears
// all 1024 slots of the slot memory; meanwhile the two-entry front queue takes at
// most two requests. The back end serves one request at a time; each slot read
// passes a read state (registered read of the single-port slot memory), then a
// check state (compare and write). A lookup walk may be followed by a walk to the
// free slot for an insert or by a backward shift of entries for a remove.
// When a request is waiting, it is accepted in the cycle after the response transfer.
module robin_hood_hash_table_core import rhh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  logic op_valid, op_ready;
  op_t op;
  logic [10:0] load_limit;

  // Load limit register
  always_ff @(posedge clk) begin
    if (rst) load_limit <= LoadLimitReset;
    else if (cfg_we) load_limit <= cfg_wdata;
  end

  rhh_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
    .op_valid(op_valid), .op_ready(op_ready), .op(op)
  );

  rhh_back u_back (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .load_limit(load_limit), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_data)
  );
endmodule

### rtl/rhh_checker.sv
// Port-level checker for the hash table core, with its bind.
`timescale 1ns / 1ps
module rhh_checker import rhh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_REMOVED) else $error("bad status");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count <= 11'(TableSize)) else $error("count range");
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL)
    |-> out_data.found_data == '0 && out_data.slot == '0) else $error("zero fields");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("reset");
endmodule

bind robin_hood_hash_table_core rhh_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
